// File: hdl/rwpg_pkg.sv
// ============================================================================
// rwpg_pkg - shared types and constants for the rainbow wheel pixel generator
// Widths, register map and the queue entry that links front and back.
// ============================================================================
package rwpg_pkg;

    localparam int MAX_LEDS   = 1024;
    localparam int IDX_W      = 10;
    localparam int LEN_W      = 11;
    localparam int COLOR_W    = 8;
    localparam int PHASE_W    = 8;
    localparam int QUOT_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] NUM_LEDS_RESET = LEN_W'(60);
    localparam logic [LEN_W-1:0] MAX_LEDS_LEN   = LEN_W'(MAX_LEDS);

    // register index, taken from paddr[2]
    localparam logic REG_NUM_LEDS = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [PHASE_W-1:0] phase;
    } rwpg_item_t;

endpackage

// File: hdl/rwpg_front.sv
// ============================================================================
// rwpg_front - input acceptance, index clamp and phase tracking
// Clamps each index to the strip, tags it with the current phase and
// advances the phase after an end-of-frame beat.
// ============================================================================
module rwpg_front
    import rwpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LEN_W-1:0]   strip_len,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IDX_W-1:0]   led_index,
    input  logic               end_of_frame,
    output logic               push,
    output rwpg_item_t         push_item,
    input  logic               queue_full
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [LEN_W-1:0]   idx_ext;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign idx_ext  = LEN_W'(led_index);

    // clamp past-the-end indices to the last LED
    always_comb
    begin
        push_item.phase = phase_reg;
        if (idx_ext >= strip_len)
        begin
            push_item.idx = IDX_W'(strip_len - LEN_W'(1));
        end
        else
        begin
            push_item.idx = led_index;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (push && end_of_frame)
        begin
            phase_next = phase_reg + PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: hdl/rwpg_queue.sv
// ============================================================================
// rwpg_queue - two-entry queue between front and back
// Holds clamped items so that front and back stall independently.
// ============================================================================
module rwpg_queue
    import rwpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rwpg_item_t  push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output rwpg_item_t  head
);

    rwpg_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/rwpg_back.sv
// ============================================================================
// rwpg_back - wheel position divider, colour ramps and output register
// Restoring division gives idx*256/len one quotient bit a cycle, then the
// position is mapped to RGB and held in the output register.
// ============================================================================
module rwpg_back
    import rwpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LEN_W-1:0]   strip_len,
    input  logic               item_avail,
    input  rwpg_item_t         item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COLOR_W-1:0] red,
    output logic [COLOR_W-1:0] green,
    output logic [COLOR_W-1:0] blue
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [2:0]          step_reg;
    logic [2:0]          step_next;
    logic [IDX_W-1:0]    rem_reg;
    logic [IDX_W-1:0]    rem_next;
    logic [QUOT_W-1:0]   quot_reg;
    logic [QUOT_W-1:0]   quot_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COLOR_W-1:0]  red_reg;
    logic [COLOR_W-1:0]  green_reg;
    logic [COLOR_W-1:0]  blue_reg;
    logic                load_out;

    logic [LEN_W-1:0]    rem_shift;
    logic                fits;
    logic [COLOR_W-1:0]  pos;
    logic [COLOR_W-1:0]  ramp_p;
    logic [COLOR_W-1:0]  up;
    logic [COLOR_W-1:0]  down;
    logic [COLOR_W-1:0]  red_new;
    logic [COLOR_W-1:0]  green_new;
    logic [COLOR_W-1:0]  blue_new;

    // one restoring step: remainder stays below the strip length
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = (rem_shift >= strip_len);

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == ST_IDLE) && item_avail;

    // colour wheel: three linear ramps in steps of 3
    always_comb
    begin
        pos = quot_reg + phase_reg;
        if (pos < 8'd85)
        begin
            ramp_p = pos;
        end
        else if (pos < 8'd170)
        begin
            ramp_p = pos - 8'd85;
        end
        else
        begin
            ramp_p = pos - 8'd170;
        end
        up   = COLOR_W'({ramp_p, 1'b0} + {1'b0, ramp_p});
        down = 8'd255 - up;
        if (pos < 8'd85)
        begin
            red_new   = up;
            green_new = down;
            blue_new  = '0;
        end
        else if (pos < 8'd170)
        begin
            red_new   = down;
            green_new = '0;
            blue_new  = up;
        end
        else
        begin
            red_new   = '0;
            green_new = up;
            blue_new  = down;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_avail)
                begin
                    rem_next   = item.idx;
                    phase_next = item.phase;
                    quot_next  = '0;
                    step_next  = 3'd7;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quot_next = {quot_reg[QUOT_W-2:0], fits};
                rem_next  = fits ? IDX_W'(rem_shift - strip_len) : IDX_W'(rem_shift);
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        phase_reg <= phase_next;
        if (load_out)
        begin
            red_reg   <= red_new;
            green_reg <= green_new;
            blue_reg  <= blue_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// File: hdl/rainbow_wheel_pixel_generator.sv
// ============================================================================
// rainbow_wheel_pixel_generator - rainbow colour per LED of a strip
// Places each LED on a 256-step colour wheel and returns its RGB triple.
// ============================================================================
// Path: a beat is popped out of the queue, goes through 8 divider
//   steps, then is colour mapped into the output register.
// Throughput: the bit-serial divider works on one pixel at a time.
// Reset: rst_n clears phase to 0, num_leds to 60, queue and output valid.
// ============================================================================
module rainbow_wheel_pixel_generator
    import rwpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel requests
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IDX_W-1:0]      led_index,
    input  logic                  end_of_frame,
    // colours
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_W-1:0]    red,
    output logic [COLOR_W-1:0]    green,
    output logic [COLOR_W-1:0]    blue
);

    logic [LEN_W-1:0] num_leds_reg;
    logic [LEN_W-1:0] num_leds_next;
    logic [LEN_W-1:0] strip_len;
    logic             cfg_write;

    logic             push;
    rwpg_item_t       push_item;
    logic             queue_full;
    logic             pop;
    logic             queue_avail;
    rwpg_item_t       head;

    // The register port never stalls; a write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        num_leds_next = num_leds_reg;
        if (cfg_write && (paddr[2] == REG_NUM_LEDS))
        begin
            num_leds_next = pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NUM_LEDS)
        begin
            prdata = APB_DATA_W'(num_leds_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_leds_reg <= NUM_LEDS_RESET;
        end
        else
        begin
            num_leds_reg <= num_leds_next;
        end
    end

    // Effective strip length: zero acts as one, anything past the
    // supported maximum is held at the maximum.
    always_comb
    begin
        priority if (num_leds_reg == '0)
        begin
            strip_len = LEN_W'(1);
        end
        else if (num_leds_reg > MAX_LEDS_LEN)
        begin
            strip_len = MAX_LEDS_LEN;
        end
        else
        begin
            strip_len = num_leds_reg;
        end
    end

    // Front: accept a beat, clamp the index, tag it with the phase.
    rwpg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .strip_len    (strip_len),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .led_index    (led_index),
        .end_of_frame (end_of_frame),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    // Queue: decouple the front from the divider.
    rwpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_avail),
        .head      (head)
    );

    // Back: divide, map onto the wheel, hold the result for the sink.
    rwpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .strip_len  (strip_len),
        .item_avail (queue_avail),
        .item       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

// File: tb/rainbow_wheel_pixel_generator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rainbow_wheel_pixel_generator_tb - self-checking bench for the wheel colors
// Drives pixel requests and strip-length writes, predicts every RGB beat with
// an in-bench color wheel model and compares each output beat in order.
// ============================================================================
module rainbow_wheel_pixel_generator_tb;
    import rwpg_pkg::*;

    // Wheel segment boundaries and the ramp ceiling.
    localparam int WHEEL_STEPS   = 256;
    localparam int SEG_BLUE_LO   = 85;
    localparam int SEG_GREEN_LO  = 170;
    localparam int RAMP_TOP      = 255;
    localparam int RAMP_STEP     = 3;

    // Register map: register i sits at byte address 4*i.
    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_LEDS = {REG_NUM_LEDS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE    = {~REG_NUM_LEDS, 2'b00};

    localparam int IDLE_PERCENT = 6;
    localparam int DRAIN_CYCLES = 16;   // settle time after the last owed beat

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [IDX_W-1:0]      led_index;
    logic                  end_of_frame;
    logic                  out_valid;
    logic                  out_ready;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;

    // Bench copy of the block's register and phase.
    logic [LEN_W-1:0]      strip_setting;
    logic [PHASE_W-1:0]    wheel_phase;

    // Colors owed by the block, oldest first.
    rgb_t                  pending_colors[$];
    int                    mismatch_count;
    bit                    full_rate;        // when set, neither side idles

    rainbow_wheel_pixel_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .led_index    (led_index),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    // 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("rainbow_wheel_pixel_generator_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Color wheel model
    // ------------------------------------------------------------------------

    // Effective strip length: zero reads as one, anything past MAX_LEDS clips.
    function automatic int strip_span();
        int n;
        n = strip_setting;
        if (n == 0)
            n = 1;
        if (n > MAX_LEDS)
            n = MAX_LEDS;
        return n;
    endfunction

    // Map a wheel position onto the three linear ramps.
    function automatic rgb_t wheel_rgb(input int pos);
        rgb_t c;
        int   p;
        if (pos < SEG_BLUE_LO)
        begin
            p       = pos;
            c.red   = COLOR_W'(p * RAMP_STEP);
            c.green = COLOR_W'(RAMP_TOP - p * RAMP_STEP);
            c.blue  = '0;
        end
        else if (pos < SEG_GREEN_LO)
        begin
            p       = pos - SEG_BLUE_LO;
            c.red   = COLOR_W'(RAMP_TOP - p * RAMP_STEP);
            c.green = '0;
            c.blue  = COLOR_W'(p * RAMP_STEP);
        end
        else
        begin
            p       = pos - SEG_GREEN_LO;
            c.red   = '0;
            c.green = COLOR_W'(p * RAMP_STEP);
            c.blue  = COLOR_W'(RAMP_TOP - p * RAMP_STEP);
        end
        return c;
    endfunction

    // Queue the color for one accepted request, then advance the phase on
    // the frame's last pixel.
    function automatic void predict_pixel(input logic [IDX_W-1:0] idx, input logic eof);
        int n;
        int i;
        int pos;
        n = strip_span();
        i = idx;
        if (i >= n)
            i = n - 1;
        pos = ((i * WHEEL_STEPS) / n + wheel_phase) % WHEEL_STEPS;
        pending_colors.push_back(wheel_rgb(pos));
        if (eof)
            wheel_phase = wheel_phase + 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random backpressure and in-order compare
    // ------------------------------------------------------------------------

    // Drop ready now and then, unless a full-rate stretch is running.
    always @(negedge clk)
    begin
        out_ready <= full_rate || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("unexpected color beat: red %0d green %0d blue %0d",
                       red, green, blue);
                mismatch_count++;
            end
            else
            begin
                want = pending_colors.pop_front();
                if (red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, red);
                    mismatch_count++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, green);
                    mismatch_count++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, blue);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks (entered and left on a falling edge)
    // ------------------------------------------------------------------------

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Check that the strip-length register holds what the model holds.
    task automatic check_strip_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_read(ADDR_NUM_LEDS, rd);
        if (rd[LEN_W-1:0] !== strip_setting)
        begin
            $error("num_leds: expected %0d, got %0d", strip_setting, rd[LEN_W-1:0]);
            mismatch_count++;
        end
    endtask

    // Drop valid and hold off until every owed color has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(negedge clk);
    endtask

    // Write num_leds with junk in the unused upper bits, then read it back.
    task automatic set_strip_length(input logic [LEN_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        wait_drained();
        word = $urandom();
        word[LEN_W-1:0] = value;
        apb_write(ADDR_NUM_LEDS, word);
        strip_setting = value;
        check_strip_readback();
    endtask

    // Send one pixel request beat, idling first now and then.
    task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic eof);
        while (!full_rate && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid     <= 1'b0;
            led_index    <= IDX_W'($urandom());
            end_of_frame <= 1'($urandom());
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        led_index    <= idx;
        end_of_frame <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pixel(idx, eof);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset value of num_leds (60) and phase (0).
    task automatic test_reset_state();
        check_strip_readback();
        send_pixel(IDX_W'(0), 1'b0);
        send_pixel(IDX_W'(59), 1'b0);
        send_pixel(IDX_W'(30), 1'b0);
    endtask

    // With 256 LEDs the index is the wheel position: hit each segment edge,
    // then clamp an index past the strip.
    task automatic test_wheel_segments();
        set_strip_length(LEN_W'(WHEEL_STEPS));
        send_pixel(IDX_W'(0), 1'b0);
        send_pixel(IDX_W'(SEG_BLUE_LO - 1), 1'b0);
        send_pixel(IDX_W'(SEG_BLUE_LO), 1'b0);
        send_pixel(IDX_W'(SEG_GREEN_LO - 1), 1'b0);
        send_pixel(IDX_W'(SEG_GREEN_LO), 1'b0);
        send_pixel(IDX_W'(WHEEL_STEPS - 1), 1'b0);
        send_pixel({IDX_W{1'b1}}, 1'b1);
        // phase is now one: the top of the wheel wraps back to zero
        send_pixel(IDX_W'(WHEEL_STEPS - 1), 1'b0);
    endtask

    // Zero length, single LED, exactly MAX_LEDS and past MAX_LEDS.
    task automatic test_strip_limits();
        set_strip_length('0);
        send_pixel(IDX_W'(0), 1'b0);
        send_pixel({IDX_W{1'b1}}, 1'b0);
        set_strip_length(LEN_W'(1));
        send_pixel(IDX_W'(5), 1'b1);
        set_strip_length(MAX_LEDS_LEN);
        send_pixel({IDX_W{1'b1}}, 1'b0);
        send_pixel(IDX_W'(MAX_LEDS / 2), 1'b0);
        set_strip_length({LEN_W{1'b1}});
        send_pixel({IDX_W{1'b1}}, 1'b0);
        send_pixel(IDX_W'(1), 1'b0);
    endtask

    // Writes to the spare register index must leave num_leds alone.
    task automatic test_spare_register();
        set_strip_length(LEN_W'(7));
        apb_write(ADDR_SPARE, $urandom());
        check_strip_readback();
        send_pixel(IDX_W'(3), 1'b0);
        send_pixel(IDX_W'(6), 1'b1);
    endtask

    // Random strip lengths, each carrying short frames of random pixels.
    task automatic test_random_frames(input int beats);
        int               sent;
        int               span;
        int               phase_beats;
        int               frame_len;
        logic [IDX_W-1:0] idx;
        logic             eof;
        sent = 0;
        while (sent < beats)
        begin
            case ($urandom_range(0, 9))
                0:       set_strip_length('0);
                1:       set_strip_length(LEN_W'(1));
                2:       set_strip_length(LEN_W'(2));
                3:       set_strip_length(NUM_LEDS_RESET);
                4:       set_strip_length(MAX_LEDS_LEN);
                5:       set_strip_length({LEN_W{1'b1}});
                6:       set_strip_length(LEN_W'($urandom_range(0, 2047)));
                default: set_strip_length(LEN_W'($urandom_range(3, 300)));
            endcase
            span        = strip_span();
            phase_beats = $urandom_range(60, 140);
            while (phase_beats > 0 && sent < beats)
            begin
                // hold the sender now and then until the block is empty
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                frame_len = $urandom_range(1, 5);
                for (int k = 0; k < frame_len; k++)
                begin
                    if ($urandom_range(0, 99) < 85)
                        idx = IDX_W'($urandom_range(0, span - 1));
                    else
                        idx = IDX_W'($urandom());
                    eof = (k == frame_len - 1) || ($urandom_range(0, 99) < 3);
                    send_pixel(idx, eof);
                    sent++;
                    phase_beats--;
                end
            end
        end
    endtask

    // Long stretch with both sides at full rate.
    task automatic test_back_to_back(input int beats);
        full_rate = 1'b1;
        set_strip_length(LEN_W'($urandom_range(1, MAX_LEDS)));
        for (int k = 0; k < beats; k++)
            send_pixel(IDX_W'($urandom()), 1'($urandom_range(0, 3) == 0));
        full_rate = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // hold every input at a known value from time zero
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        led_index      = '0;
        end_of_frame   = 1'b0;
        out_ready      = 1'b0;
        full_rate      = 1'b0;
        mismatch_count = 0;
        strip_setting  = NUM_LEDS_RESET;
        wheel_phase    = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_wheel_segments();
        test_strip_limits();
        test_spare_register();
        test_random_frames(920);
        test_back_to_back(150);
        test_random_frames(60);

        // drop valid, drain what is owed, then let the pipe settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("rainbow_wheel_pixel_generator_tb: PASS");
        else
            $display("rainbow_wheel_pixel_generator_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/rwpg_pkg.sv
hdl/rwpg_front.sv
hdl/rwpg_queue.sv
hdl/rwpg_back.sv
hdl/rainbow_wheel_pixel_generator.sv
tb/rainbow_wheel_pixel_generator_tb.sv
